FILE: hdl/epf_pkg.sv
// epf_pkg: shared constants, codes, types and helpers of the eulerian path finder
// used by epf_graph and eulerian_path_finder; no dependencies
package epf_pkg;

   localparam int NUM_NODES   = 16;
   localparam int MAX_EDGES   = 63;
   localparam int STORE_DEPTH = 64;

   localparam int NODE_W = 4;
   localparam int ACT_W  = 2;
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int PTR_W  = $clog2(STORE_DEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      GOP_NONE,
      GOP_ADD,
      GOP_TAKE,
      GOP_CLEAR
   } epf_gop_type;

   typedef struct packed {
      epf_gop_type       op;
      logic [NODE_W-1:0] sel;
      logic [NODE_W-1:0] dst;
   } epf_gctl_type;

   typedef struct packed {
      logic              row_any;
      logic [NODE_W-1:0] low_dst;
      logic              empty;
   } epf_gsts_type;

   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return (32'(n) < NUM_NODES);
   endfunction

endpackage

FILE: hdl/epf_ram.sv
// epf_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module epf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/epf_graph.sv
// epf_graph: adjacency bit matrix, edge counter and lowest destination search
// depends on epf_pkg
module epf_graph import epf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  epf_gctl_type ctl,
   output epf_gsts_type sts
);

   logic [NUM_NODES-1:0] adj_ff [NUM_NODES];
   logic [NUM_NODES-1:0] adj_in [NUM_NODES];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [NUM_NODES-1:0] row;
   logic [NODE_W-1:0]    low;

   assign row = adj_ff[ctl.sel];

   // priority search for the lowest set bit
   always_comb begin
      low = '0;
      for (int j = NUM_NODES - 1; j >= 0; j--) begin
         if (row[j]) begin
            low = NODE_W'(j);
         end
      end
   end

   always_comb begin
      adj_in   = adj_ff;
      count_in = count_ff;
      case (ctl.op)
         GOP_ADD: begin
            if (node_ok(ctl.sel) && node_ok(ctl.dst) && count_ff < CNT_W'(MAX_EDGES)
                && !row[ctl.dst]) begin
               adj_in[ctl.sel][ctl.dst] = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         GOP_TAKE: begin
            if (row != '0) begin
               adj_in[ctl.sel][low] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         GOP_CLEAR: begin
            adj_in   = '{default: '0};
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff   <= '{default: '0};
         count_ff <= '0;
      end else begin
         adj_ff   <= adj_in;
         count_ff <= count_in;
      end
   end

   assign sts.row_any = (row != '0);
   assign sts.low_dst = low;
   assign sts.empty   = (count_ff == '0);

endmodule

FILE: hdl/eulerian_path_finder.sv
// eulerian_path_finder: top level, walk sequencer with stack and path store
// depends on epf_pkg, epf_ram, epf_graph
//
// channel   direction  handshake             payload
// req       in         start and not busy    req_action req_src_node req_dst_node req_start_node
// rsp       out        rsp_strobe one cycle  rsp_path_node rsp_last rsp_complete
//
// add and clear leave busy low
// a run keeps busy high while it walks: each push is a walk step, each pop but the
// final one passes through a load state (stack ram registered read), each path node
// is emitted in turn, and busy stays high while the last result shows
// reset clears the graph and the sequencer at once; no clearing pass
// results cannot be stalled; busy is high from a run's acceptance to its last result
module eulerian_path_finder import epf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [NODE_W-1:0] req_src_node,
   input  logic [NODE_W-1:0] req_dst_node,
   input  logic [NODE_W-1:0] req_start_node,
   output logic              rsp_strobe,
   output logic [NODE_W-1:0] rsp_path_node,
   output logic              rsp_last,
   output logic              rsp_complete
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LOAD,
      S_EMIT,
      S_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  sp_ff, sp_in;
   logic [PTR_W-1:0]  plen_ff, plen_in;
   logic [ADDR_W-1:0] eidx_ff, eidx_in;
   logic [NODE_W-1:0] top_ff, top_in;
   logic              start_ok_ff, start_ok_in;
   logic              strobe_ff, strobe_in;
   logic              last_ff, last_in;
   logic              complete_ff, complete_in;

   epf_gctl_type      gctl;
   epf_gsts_type      gsts;

   logic              stk_we;
   logic [ADDR_W-1:0] stk_waddr;
   logic [NODE_W-1:0] stk_wdata;
   logic [ADDR_W-1:0] stk_raddr;
   logic [NODE_W-1:0] stk_rdata;
   logic              pth_we;
   logic [ADDR_W-1:0] pth_waddr;
   logic [NODE_W-1:0] pth_wdata;
   logic [ADDR_W-1:0] pth_raddr;
   logic [NODE_W-1:0] pth_rdata;

   logic              can_push;
   logic [PTR_W-1:0]  plen_nx;

   epf_graph u_graph (
      .clock (clock),
      .reset (reset),
      .ctl   (gctl),
      .sts   (gsts)
   );

   epf_ram #(.WIDTH(NODE_W), .DEPTH(STORE_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   epf_ram #(.WIDTH(NODE_W), .DEPTH(STORE_DEPTH)) u_path (
      .clock   (clock),
      .wr_en   (pth_we),
      .wr_addr (pth_waddr),
      .wr_data (pth_wdata),
      .rd_addr (pth_raddr),
      .rd_data (pth_rdata)
   );

   assign can_push = start_ok_ff && node_ok(top_ff) && gsts.row_any
                     && (sp_ff < PTR_W'(STORE_DEPTH));
   assign plen_nx  = (plen_ff < PTR_W'(STORE_DEPTH)) ? plen_ff + PTR_W'(1) : plen_ff;

   always_comb begin
      state_in    = state_ff;
      sp_in       = sp_ff;
      plen_in     = plen_ff;
      eidx_in     = eidx_ff;
      top_in      = top_ff;
      start_ok_in = start_ok_ff;
      strobe_in   = 1'b0;
      last_in     = 1'b0;
      complete_in = 1'b0;

      gctl.op  = GOP_NONE;
      gctl.sel = top_ff;
      gctl.dst = req_dst_node;

      stk_we    = 1'b0;
      stk_waddr = sp_ff[ADDR_W-1:0];
      stk_wdata = gsts.low_dst;
      stk_raddr = ADDR_W'(sp_ff - PTR_W'(2));
      pth_we    = 1'b0;
      pth_waddr = plen_ff[ADDR_W-1:0];
      pth_wdata = top_ff;
      pth_raddr = eidx_ff;

      case (state_ff)
         S_IDLE: begin
            gctl.sel = req_src_node;
            if (start) begin
               case (req_action)
                  ACT_ADD: begin
                     gctl.op = GOP_ADD;
                  end
                  ACT_RUN: begin
                     stk_we      = 1'b1;
                     stk_waddr   = '0;
                     stk_wdata   = req_start_node;
                     top_in      = req_start_node;
                     start_ok_in = node_ok(req_start_node);
                     sp_in       = PTR_W'(1);
                     plen_in     = '0;
                     state_in    = S_WALK;
                  end
                  ACT_CLEAR: begin
                     gctl.op = GOP_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (can_push) begin
               gctl.op = GOP_TAKE;
               stk_we  = 1'b1;
               top_in  = gsts.low_dst;
               sp_in   = sp_ff + PTR_W'(1);
            end else begin
               pth_we  = (plen_ff < PTR_W'(STORE_DEPTH));
               plen_in = plen_nx;
               sp_in   = sp_ff - PTR_W'(1);
               if (sp_ff == PTR_W'(1)) begin
                  eidx_in  = ADDR_W'(plen_nx - PTR_W'(1));
                  state_in = S_EMIT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            top_in   = stk_rdata;
            state_in = S_WALK;
         end
         S_EMIT: begin
            strobe_in = 1'b1;
            if (eidx_ff == '0) begin
               last_in     = 1'b1;
               complete_in = gsts.empty;
               state_in    = S_DRAIN;
            end else begin
               eidx_in = eidx_ff - ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         sp_ff       <= '0;
         plen_ff     <= '0;
         eidx_ff     <= '0;
         start_ok_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
         complete_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sp_ff       <= sp_in;
         plen_ff     <= plen_in;
         eidx_ff     <= eidx_in;
         start_ok_ff <= start_ok_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
         complete_ff <= complete_in;
      end
      top_ff <= top_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_path_node = pth_rdata;
   assign rsp_last      = last_ff;
   assign rsp_complete  = complete_ff;

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without a result");

   a_complete_last: assert property (@(posedge clock) disable iff (reset)
      rsp_complete |-> rsp_last)
      else $error("complete flag before the last item");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_strobe)
      else $error("result after the last item");

   a_walk_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (sp_ff != '0 && sp_ff <= PTR_W'(STORE_DEPTH)))
      else $error("walk stack pointer out of range");

endmodule
